@@ src/sha256_hash_engine_unit_defines.svh @@
// Assertion macros shared by the hash engine RTL.
`ifndef SHA256_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA256_HASH_ENGINE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Types, round constants and mixing functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

	localparam int BLK_WORDS = 16;
	localparam int Q_DEPTH   = 2;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_BYTE = 6'd63;
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [2:0] MAX_COUNT = 3'd4;
	localparam logic [2:0] LAST_IDX  = 3'd7;
	localparam logic [5:0] LAST_RND  = 6'd63;

	// One full block handed from the front to the back.
	typedef struct packed {
		logic                        fin;
		logic [BLK_WORDS-1:0][31:0]  words;
	} blk_t;

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

@@ src/sha_front.sv @@
// ----------------------------------------------------------------------------
// sha_front
// Takes message items, packs bytes into the block buffer one per cycle while no
// full block waits for the queue, counts message bits, appends padding and length on the last item.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [31:0]       data_word,
	input  wire logic [2:0]        byte_count,
	input  wire logic              last,
	output      logic              push,
	output      sha_pkg::blk_t     push_blk,
	input  wire logic              q_full
);
	import sha_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_BYTES, F_PAD} fstate_t;

	fstate_t      state_q;
	logic [31:0]  data_q;
	logic [2:0]   cnt_q;
	logic [2:0]   k_q;
	logic         last_q;
	logic         first_q;
	logic [5:0]   fill_q;
	logic [63:0]  bc_q;
	logic         full_q;
	logic         fin_q;
	logic [BLK_WORDS-1:0][31:0] buf_q;

	logic         wr_en;
	logic [7:0]   wr_byte;
	logic         len_wr;
	logic [7:0]   cur_byte;

	assign in_stall = (state_q != F_IDLE) || full_q;
	assign push     = full_q && !q_full;
	assign push_blk = '{fin: fin_q, words: buf_q};

	// Pick the next message byte of the held item
	always_comb begin
		unique case (k_q[1:0])
			2'd0: cur_byte = data_q[31:24];
			2'd1: cur_byte = data_q[23:16];
			2'd2: cur_byte = data_q[15:8];
			default: cur_byte = data_q[7:0];
		endcase
	end

	// Decide what goes into the buffer this cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = 8'h00;
		len_wr  = 1'b0;
		if (!full_q) begin
			unique case (state_q)
				F_BYTES: begin
					if (k_q < cnt_q) begin
						wr_en   = 1'b1;
						wr_byte = cur_byte;
					end
				end
				F_PAD: begin
					if (first_q) begin
						wr_en   = 1'b1;
						wr_byte = PAD_BYTE;
					end else if (fill_q == LEN_POS) begin
						len_wr = 1'b1;
					end else begin
						wr_en = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Write one byte or the length words into the buffer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			unique case (fill_q[1:0])
				2'd0: buf_q[fill_q[5:2]][31:24] <= wr_byte;
				2'd1: buf_q[fill_q[5:2]][23:16] <= wr_byte;
				2'd2: buf_q[fill_q[5:2]][15:8]  <= wr_byte;
				default: buf_q[fill_q[5:2]][7:0] <= wr_byte;
			endcase
		end
		if (len_wr) begin
			buf_q[14] <= bc_q[63:32];
			buf_q[15] <= bc_q[31:0];
		end
	end

	// Sequence items, padding and block hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			data_q  <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
			first_q <= 1'b0;
			fill_q  <= '0;
			bc_q    <= '0;
			full_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (push) begin
				full_q <= 1'b0;
			end
			if (!full_q) begin
				unique case (state_q)
					F_IDLE: begin
						if (in_valid) begin
							data_q  <= data_word;
							cnt_q   <= (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
							last_q  <= last;
							k_q     <= '0;
							state_q <= F_BYTES;
						end
					end
					F_BYTES: begin
						if (k_q < cnt_q) begin
							fill_q <= fill_q + 6'd1;
							bc_q   <= bc_q + 64'd8;
							k_q    <= k_q + 3'd1;
							if (fill_q == LAST_BYTE) begin
								full_q <= 1'b1;
								fin_q  <= 1'b0;
							end
						end else if (last_q) begin
							first_q <= 1'b1;
							state_q <= F_PAD;
						end else begin
							state_q <= F_IDLE;
						end
					end
					F_PAD: begin
						if (!first_q && fill_q == LEN_POS) begin
							full_q  <= 1'b1;
							fin_q   <= 1'b1;
							fill_q  <= '0;
							bc_q    <= '0;
							state_q <= F_IDLE;
						end else begin
							first_q <= 1'b0;
							fill_q  <= fill_q + 6'd1;
							if (fill_q == LAST_BYTE) begin
								full_q <= 1'b1;
								fin_q  <= 1'b0;
							end
						end
					end
					default: state_q <= F_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ src/sha_queue.sv @@
// ----------------------------------------------------------------------------
// sha_queue
// Two-entry block queue between the front and the compression back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_unit_defines.svh"
module sha_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sha_pkg::blk_t  push_blk,
	output      logic           full,
	input  wire logic           pop,
	output      sha_pkg::blk_t  head_blk,
	output      logic           empty
);
	import sha_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	blk_t              mem_q [Q_DEPTH];
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [PW:0]       count_q;

	assign full     = (count_q == (PW+1)'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign head_blk = mem_q[rp_q];

	// Store pushed blocks
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_blk;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SHA_ASSERT(a_q_bound, clk, arst_n, count_q <= (PW+1)'(Q_DEPTH), "queue overfilled")
	`SHA_ASSERT(a_q_nopush, clk, arst_n, full |-> !push, "push into full queue")
	`SHA_ASSERT(a_q_nopop, clk, arst_n, empty |-> !pop, "pop from empty queue")

endmodule
`default_nettype wire

@@ src/sha_back.sv @@
// ----------------------------------------------------------------------------
// sha_back
// Runs the 64-round compression on each queued block, one round per cycle,
// and shows the eight digest words after the final block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_unit_defines.svh"
module sha_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire sha_pkg::blk_t  head_blk,
	output      logic           pop,
	output      logic           out_valid,
	input  wire logic           out_stall,
	output      logic [31:0]    digest_word,
	output      logic [2:0]     word_index,
	output      logic           digest_last
);
	import sha_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} bstate_t;

	bstate_t      state_q;
	logic [5:0]   rnd_q;
	logic [2:0]   idx_q;
	logic         fin_q;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [BLK_WORDS];

	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  w_new;

	assign pop         = (state_q == B_IDLE) && !q_empty;
	assign out_valid   = (state_q == B_OUT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign digest_last = (idx_q == LAST_IDX);

	// One round of mixing and the next schedule word
	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TAB[rnd_q] + w_q[0];
		t2 = big_sig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + sml_sig0(w_q[1]) + w_q[9] + sml_sig1(w_q[14]);
	end

	// Load, shift and mix working data
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < BLK_WORDS; i++) begin
				w_q[i] <= head_blk.words[i];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == B_ROUND) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLK_WORDS-1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Sequence rounds, hash update and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= IV_TAB[i];
			end
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						fin_q   <= head_blk.fin;
						rnd_q   <= '0;
						state_q <= B_ROUND;
					end
				end
				B_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_RND) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					idx_q   <= '0;
					state_q <= fin_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (!out_stall) begin
						if (idx_q == LAST_IDX) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= IV_TAB[i];
							end
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`SHA_ASSERT(a_b_pop_idle, clk, arst_n, pop |=> (state_q == B_ROUND && rnd_q == '0),
		"block pop did not start rounds")
	`SHA_ASSERT(a_b_out_fin, clk, arst_n, out_valid |-> fin_q, "digest shown for inner block")
	`SHA_ASSERT(a_b_add, clk, arst_n, (state_q == B_ROUND && rnd_q == LAST_RND) |=>
		(state_q == B_ADD), "round count overrun")

endmodule
`default_nettype wire

@@ src/sha256_hash_engine_unit.sv @@
// SHA-256 engine: the front accepts an item, writes its bytes one per cycle unless a full block
// waits for queue space, then wraps up; the back pops a block, runs its 64 rounds and adds the
// result into the hash value; a two-block queue decouples the two sides.
// After the last item the front writes padding and length, then one or two compressions follow.
// The eight digest words follow at one per cycle while the output is not stalled.
// Reset loads the initial hash value and clears counters and queue; no clearing pass is run.
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// Top level: byte-packing front, block queue and compression back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_hash_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] digest_word,
	output      logic [2:0]  word_index,
	output      logic        digest_last
);
	import sha_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	blk_t  push_blk;
	blk_t  head_blk;

	// Accept items and build padded blocks
	sha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.push       (push),
		.push_blk   (push_blk),
		.q_full     (q_full)
	);

	// Hold blocks between the two sides
	sha_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_blk (push_blk),
		.full     (q_full),
		.pop      (pop),
		.head_blk (head_blk),
		.empty    (q_empty)
	);

	// Compress blocks and emit the digest
	sha_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_blk    (head_blk),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.digest_last (digest_last)
	);

endmodule
`default_nettype wire

@@ bench/sha256_digest_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the input and digest channels of the hash engine, runs its own
// SHA-256 over the accepted message bytes and compares every digest word.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_digest_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] digest_word,
	input  wire logic [2:0]  word_index,
	input  wire logic        digest_last,
	output int               fail_count,
	output int               pending_words,
	output int               digests_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        fin;
	} digest_t;

	logic [31:0] chain [8];
	logic [31:0] msg_block [16];
	logic [63:0] msg_bits;
	logic [5:0]  block_fill;
	digest_t     digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run the 64 rounds over the buffered block and fold into the chain value.
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++) w[i] = msg_block[i];
		for (int i = 16; i < 64; i++) begin
			w[i] = w[i-16] + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TAB[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
	endtask

	task automatic place_byte(input logic [7:0] b);
		msg_block[block_fill[5:2]][8*(3-block_fill[1:0]) +: 8] = b;
		block_fill = block_fill + 6'd1;
	endtask

	// Absorb one accepted item; on the last one pad, finish and queue the digest.
	task automatic absorb(input logic [31:0] d, input logic [2:0] cnt, input logic fin);
		int n;
		n = (cnt > sha_pkg::MAX_COUNT) ? 4 : cnt;
		for (int k = 0; k < n; k++) begin
			place_byte(d[8*(3-k) +: 8]);
			msg_bits = msg_bits + 64'd8;
			if (block_fill == 6'd0) compress();
		end
		if (!fin) return;
		place_byte(sha_pkg::PAD_BYTE);
		if (block_fill > sha_pkg::LEN_POS || block_fill == 6'd0) begin
			while (block_fill != 6'd0) place_byte(8'h00);
			compress();
		end
		while (block_fill < sha_pkg::LEN_POS) place_byte(8'h00);
		msg_block[14] = msg_bits[63:32];
		msg_block[15] = msg_bits[31:0];
		compress();
		for (int k = 0; k < 8; k++)
			digest_q.push_back('{chain[k], 3'(k), k == 7});
		for (int k = 0; k < 8; k++) chain[k] = sha_pkg::IV_TAB[k];
		msg_bits = '0;
		block_fill = '0;
	endtask

	// Predict on input items, compare on digest items.
	always @(posedge clk or negedge arst_n) begin
		digest_t exp_d;
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) chain[k] = sha_pkg::IV_TAB[k];
			for (int k = 0; k < 16; k++) msg_block[k] = '0;
			msg_bits = '0;
			block_fill = '0;
			digest_q.delete();
			fail_count <= 0;
			digests_seen <= 0;
		end else begin
			if (in_valid && !in_stall) absorb(data_word, byte_count, last);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%0t: digest item with none expected: word %h idx %0d last %b",
						$realtime, digest_word, word_index, digest_last);
					fail_count <= fail_count + 1;
				end else begin
					exp_d = digest_q.pop_front();
					if (exp_d.word !== digest_word || exp_d.idx !== word_index
							|| exp_d.fin !== digest_last) begin
						$display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
							$realtime, exp_d.word, exp_d.idx, exp_d.fin,
							digest_word, word_index, digest_last);
						fail_count <= fail_count + 1;
					end
					if (exp_d.fin) digests_seen <= digests_seen + 1;
				end
			end
		end
		pending_words = digest_q.size();
	end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// SHA-256 engine testbench
// Drives directed and random messages in bursts with a stalling receiver;
// the checker predicts each digest and reports mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last;
	logic        out_valid, out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;
	int          fail_count, pending_words, digests_seen;
	int          items_sent, messages_sent, idle_cycles;
	int          burst_left;
	logic [1:0]  stall_mode;

	sha256_hash_engine_unit DUT (.*);

	sha256_digest_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the digest side on a rotating pattern: none, light, heavy, long runs.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= '0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= 2'($urandom);
			case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
			endcase
		end
	end

	// Count cycles with no accepted item on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Hold one item until accepted; insert a random gap between bursts.
	task automatic send_item(input logic [31:0] d, input logic [2:0] cnt, input logic fin);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		data_word <= d;
		byte_count <= cnt;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
		if (fin) messages_sent++;
	endtask

	// Send a message of full words, ending with a possibly short last word.
	task automatic send_message(input int words, input logic [2:0] tail_cnt);
		for (int i = 0; i < words; i++) send_item($urandom, 3'd4, 1'b0);
		send_item($urandom, tail_cnt, 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		last = 1'b0;
		items_sent = 0;
		messages_sent = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, extremes, short words mid-message, oversize counts.
		send_item(32'h0000_0000, 3'd0, 1'b1);
		send_item(32'h6162_6300, 3'd3, 1'b1);
		send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_item(32'h0000_0000, 3'd4, 1'b1);
		send_item(32'hA5A5_A5A5, 3'd0, 1'b0);
		send_item(32'h1234_5678, 3'd1, 1'b0);
		send_item(32'h9ABC_DEF0, 3'd2, 1'b0);
		send_item(32'hFFFF_FFFF, 3'd7, 1'b0);
		send_item(32'h5555_5555, 3'd5, 1'b0);
		send_item(32'hAAAA_AAAA, 3'd6, 1'b1);
		drain();
		// Lengths 55 and 56 bytes straddle the one/two padding block boundary.
		send_message(13, 3'd3);
		send_message(13, 3'd4);
		send_message(15, 3'd4);
		send_message(15, 3'd0);

		// Random: mostly ordinary messages, some with short or empty inner words.
		while (items_sent < 370) begin
			int len, r;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 20);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 9);
				send_item($urandom, (r == 0) ? 3'($urandom) : 3'd4, 1'b0);
			end
			send_item($urandom, 3'($urandom), 1'b1);
			if ($urandom_range(0, 7) == 0) drain();
		end
		drain();
		repeat (200) @(negedge clk);

		$display("Sent %0d items in %0d messages; %0d digests checked.",
			items_sent, messages_sent, digests_seen);
		if (fail_count == 0 && pending_words == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_back.sv
src/sha256_hash_engine_unit.sv
bench/sha256_digest_checker.sv
bench/tb.sv
